/* hdl/simple_risc_instruction_execute_assert.svh */
// assertion macros shared by the execute block
`ifndef SIMPLE_RISC_INSTRUCTION_EXECUTE_ASSERT_SVH
`define SIMPLE_RISC_INSTRUCTION_EXECUTE_ASSERT_SVH

// same-cycle implication
`define SRIE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRIE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srie_pkg.sv */
`default_nettype none

package srie_pkg;

  // default data memory depth in words
  localparam int unsigned DATA_DEPTH_DEF = 65536;

  // conditional subtract steps that fold a 16-bit address into the smallest depth (256)
  localparam int unsigned FOLD_STEPS = 8;

  // instruction field positions
  localparam int unsigned OPC_HI = 29;
  localparam int unsigned OPC_LO = 25;
  localparam int unsigned DST_HI = 24;
  localparam int unsigned DST_LO = 22;
  localparam int unsigned SRC0_HI = 21;
  localparam int unsigned SRC0_LO = 19;
  localparam int unsigned SRC1_HI = 18;
  localparam int unsigned SRC1_LO = 16;
  localparam int unsigned IMM_HI = 15;
  localparam int unsigned IMM_LO = 0;

  // opcodes
  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_LSF = 5'd2;
  localparam logic [4:0] OP_RSF = 5'd3;
  localparam logic [4:0] OP_AND = 5'd4;
  localparam logic [4:0] OP_OR  = 5'd5;
  localparam logic [4:0] OP_XOR = 5'd6;
  localparam logic [4:0] OP_LHI = 5'd7;
  localparam logic [4:0] OP_LD  = 5'd8;
  localparam logic [4:0] OP_ST  = 5'd9;
  localparam logic [4:0] OP_JLT = 5'd16;
  localparam logic [4:0] OP_JLE = 5'd17;
  localparam logic [4:0] OP_JEQ = 5'd18;
  localparam logic [4:0] OP_JNE = 5'd19;
  localparam logic [4:0] OP_JIN = 5'd20;
  localparam logic [4:0] OP_HLT = 5'd24;

  // operand selects that bypass the register file
  localparam logic [2:0] SEL_ZERO = 3'd0;
  localparam logic [2:0] SEL_IMM  = 3'd1;

  // link register
  localparam logic [2:0] REG_LINK = 3'd7;

  // input transaction
  typedef struct packed {
    logic        kind;
    logic [31:0] instruction;
    logic [15:0] program_counter;
    logic [15:0] preload_address;
    logic [31:0] preload_data;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halted;
    logic               reg_written;
    logic [2:0]         dest_reg;
    logic signed [31:0] dest_value;
    logic               branch_taken;
    logic               mispredicted;
    logic               stored;
    logic [15:0]        store_address;
    logic signed [31:0] store_value;
  } out_item_t;

  // register file write port
  typedef struct packed {
    logic        en;
    logic [2:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

  // side information from the execute unit
  typedef struct packed {
    logic        is_ld;
    logic        is_cond;
    logic [1:0]  ctr_next;
    logic [15:0] mem_addr;
  } ex_side_t;

  // operand rule: select 0 reads zero, select 1 reads the immediate
  function automatic logic [31:0] operand(input logic [2:0] sel, input logic [31:0] imm,
                                          input logic [31:0] rf_data);
    logic [31:0] v;
    case (sel)
      SEL_ZERO: v = '0;
      SEL_IMM:  v = imm;
      default:  v = rf_data;
    endcase
    return v;
  endfunction

  // address modulo depth by restoring subtraction, quotient is below 256
  function automatic logic [16:0] mem_fold(input logic [15:0] addr, input int unsigned depth);
    logic [23:0] r;
    logic [23:0] lim;
    r = {8'd0, addr};
    for (int k = FOLD_STEPS - 1; k >= 0; k--) begin
      lim = 24'(depth) << k;
      if (r >= lim) begin
        r = r - lim;
      end
    end
    return r[16:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/srie_regfile.sv */
`default_nettype none

module srie_regfile
  import srie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rd_en,
  input  wire logic [2:0]  rd_addr0,
  input  wire logic [2:0]  rd_addr1,
  input  wire rf_wr_t      wr,
  output      logic [31:0] rd_data0,
  output      logic [31:0] rd_data1
);

  logic [31:0] mem [8];
  logic [7:0]  written;

  // per-entry written flags, never-written entries read zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // write port and registered reads with write-through on a same-edge hit
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && wr.addr == rd_addr0) begin
        rd_data0 <= wr.data;
      end else begin
        rd_data0 <= written[rd_addr0] ? mem[rd_addr0] : '0;
      end
      if (wr.en && wr.addr == rd_addr1) begin
        rd_data1 <= wr.data;
      end else begin
        rd_data1 <= written[rd_addr1] ? mem[rd_addr1] : '0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/srie_dmem.sv */
`default_nettype none

module srie_dmem
  import srie_pkg::*;
#(
  parameter int unsigned DEPTH = DATA_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
)
(
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/srie_exec.sv */
`default_nettype none

module srie_exec
  import srie_pkg::*;
(
  input  wire logic [31:0] instruction,
  input  wire logic [15:0] program_counter,
  input  wire logic [31:0] rf_a,
  input  wire logic [31:0] rf_b,
  input  wire logic [1:0]  ctr,
  output      out_item_t   res,
  output      ex_side_t    side
);

  logic [4:0]  opc;
  logic [2:0]  dst;
  logic [2:0]  src0;
  logic [2:0]  src1;
  logic [31:0] imm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] lhi_old;
  logic        big_shift;
  logic [31:0] lsf_val;
  logic [31:0] rsf_val;
  logic        lt;
  logic        eq;
  logic        cond;
  logic [16:0] link;
  logic        wr;
  logic [2:0]  dreg;
  logic [31:0] dval;

  // field decode
  assign opc  = instruction[OPC_HI:OPC_LO];
  assign dst  = instruction[DST_HI:DST_LO];
  assign src0 = instruction[SRC0_HI:SRC0_LO];
  assign src1 = instruction[SRC1_HI:SRC1_LO];
  assign imm  = {{16{instruction[IMM_HI]}}, instruction[IMM_HI:IMM_LO]};

  // operands, port a carries dst for lhi
  assign a       = operand(src0, imm, rf_a);
  assign b       = operand(src1, imm, rf_b);
  assign lhi_old = operand(dst, imm, rf_a);

  // shifts, amounts of 32 or more flush out
  assign big_shift = |b[31:5];
  assign lsf_val   = big_shift ? '0 : (a << b[4:0]);
  assign rsf_val   = big_shift ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);

  // branch compares
  assign lt   = $signed(a) < $signed(b);
  assign eq   = a == b;
  assign link = {1'b0, program_counter} + 17'd1;

  always_comb begin
    case (opc)
      OP_JLT:  cond = lt;
      OP_JLE:  cond = lt || eq;
      OP_JEQ:  cond = eq;
      OP_JNE:  cond = !eq;
      default: cond = 1'b0;
    endcase
  end

  // opcode dispatch
  always_comb begin
    res           = '0;
    res.next_pc   = program_counter + 16'd1;
    side.is_ld    = 1'b0;
    side.is_cond  = 1'b0;
    side.ctr_next = ctr;
    side.mem_addr = b[15:0];
    wr            = 1'b0;
    dreg          = dst;
    dval          = '0;
    case (opc)
      OP_ADD: begin wr = 1'b1; dval = a + b; end
      OP_SUB: begin wr = 1'b1; dval = a - b; end
      OP_LSF: begin wr = 1'b1; dval = lsf_val; end
      OP_RSF: begin wr = 1'b1; dval = rsf_val; end
      OP_AND: begin wr = 1'b1; dval = a & b; end
      OP_OR:  begin wr = 1'b1; dval = a | b; end
      OP_XOR: begin wr = 1'b1; dval = a ^ b; end
      OP_LHI: begin
        wr   = 1'b1;
        dval = {imm[15:0], lhi_old[15:0]};
      end
      OP_LD: begin
        wr         = 1'b1;
        side.is_ld = 1'b1;
      end
      OP_ST: begin
        res.stored        = 1'b1;
        res.store_address = b[15:0];
        res.store_value   = a;
      end
      OP_JLT, OP_JLE, OP_JEQ, OP_JNE: begin
        side.is_cond     = 1'b1;
        res.mispredicted = ctr[1] != cond;
        if (cond) begin
          if (ctr != 2'd3) begin
            side.ctr_next = ctr + 2'd1;
          end
          res.branch_taken = 1'b1;
          res.next_pc      = imm[15:0];
          wr               = 1'b1;
          dreg             = REG_LINK;
          dval             = {15'd0, link};
        end else if (ctr != 2'd0) begin
          side.ctr_next = ctr - 2'd1;
        end
      end
      OP_JIN: begin
        res.branch_taken = 1'b1;
        res.next_pc      = a[15:0];
        wr               = 1'b1;
        dreg             = REG_LINK;
        dval             = {15'd0, link};
      end
      OP_HLT: begin
        res.halted  = 1'b1;
        res.next_pc = program_counter;
      end
      default: begin
      end
    endcase
    res.reg_written = wr;
    res.dest_reg    = wr ? dreg : '0;
    res.dest_value  = dval;
  end

endmodule

`default_nettype wire

/* hdl/simple_risc_instruction_execute.sv */
// Flow: an input transaction reaches the result through operand read, then execute and data
// memory access; one instruction per cycle sustained while results are taken, set by the
// register file and data memory read ports, with forwarding from the result stage and
// write-through reads. Preload transactions write the data memory and give no result.
// Reset: synchronous, clears pipeline valids, the branch counter (strongly not taken) and
// the register file written flags; no clearing pass, the block accepts right after reset.
`default_nettype none
`include "simple_risc_instruction_execute_assert.svh"

module simple_risc_instruction_execute
  import srie_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_item
);

  localparam int unsigned ADDR_W = $clog2(DATA_DEPTH);

  logic              in_accept;
  logic              s1_valid;
  in_item_t          s1_item;
  logic              s1_adv;
  logic              s2_take;
  logic              s2_valid;
  out_item_t         s2_res;
  logic              s2_is_ld;
  logic [1:0]        ctr;
  logic [2:0]        in_addr0;
  logic [2:0]        s1_addr0;
  logic [2:0]        s1_addr1;
  rf_wr_t            rf_wr;
  logic [31:0]       rf_data0;
  logic [31:0]       rf_data1;
  logic [31:0]       fwd_a;
  logic [31:0]       fwd_b;
  out_item_t         ex_res;
  ex_side_t          ex_side;
  logic [16:0]       pre_fold;
  logic [16:0]       ex_fold;
  logic              dm_we;
  logic [ADDR_W-1:0] dm_waddr;
  logic [31:0]       dm_wdata;
  logic              dm_re;
  logic [31:0]       dm_rdata;

  // pipeline flow: preloads leave stage 1 without a result
  assign s1_adv    = s1_valid && (s1_item.kind || !s2_valid || out_ready);
  assign s2_take   = s1_adv && !s1_item.kind;
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  // register file read addresses, port a reads dst for lhi
  assign in_addr0 = (in_item.instruction[OPC_HI:OPC_LO] == OP_LHI) ?
                    in_item.instruction[DST_HI:DST_LO] : in_item.instruction[SRC0_HI:SRC0_LO];
  assign s1_addr0 = (s1_item.instruction[OPC_HI:OPC_LO] == OP_LHI) ?
                    s1_item.instruction[DST_HI:DST_LO] : s1_item.instruction[SRC0_HI:SRC0_LO];
  assign s1_addr1 = s1_item.instruction[SRC1_HI:SRC1_LO];

  // write back when the result transaction completes
  assign rf_wr.en   = s2_valid && out_ready && s2_res.reg_written;
  assign rf_wr.addr = s2_res.dest_reg;
  assign rf_wr.data = out_item.dest_value;

  srie_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_accept),
    .rd_addr0 (in_addr0),
    .rd_addr1 (in_item.instruction[SRC1_HI:SRC1_LO]),
    .wr       (rf_wr),
    .rd_data0 (rf_data0),
    .rd_data1 (rf_data1)
  );

  // forward the pending result over the register file data
  assign fwd_a = (s2_valid && s2_res.reg_written && s2_res.dest_reg == s1_addr0) ?
                 out_item.dest_value : rf_data0;
  assign fwd_b = (s2_valid && s2_res.reg_written && s2_res.dest_reg == s1_addr1) ?
                 out_item.dest_value : rf_data1;

  srie_exec u_exec (
    .instruction     (s1_item.instruction),
    .program_counter (s1_item.program_counter),
    .rf_a            (fwd_a),
    .rf_b            (fwd_b),
    .ctr             (ctr),
    .res             (ex_res),
    .side            (ex_side)
  );

  // data memory addressing, folded into the depth
  assign pre_fold = mem_fold(s1_item.preload_address, DATA_DEPTH);
  assign ex_fold  = mem_fold(ex_side.mem_addr, DATA_DEPTH);
  assign dm_we    = s1_adv && (s1_item.kind || ex_res.stored);
  assign dm_waddr = s1_item.kind ? pre_fold[ADDR_W-1:0] : ex_fold[ADDR_W-1:0];
  assign dm_wdata = s1_item.kind ? s1_item.preload_data : ex_res.store_value;
  assign dm_re    = s2_take && ex_side.is_ld;

  srie_dmem #(
    .DEPTH (DATA_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (ex_fold[ADDR_W-1:0]),
    .rdata (dm_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      ctr      <= 2'd0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_take) begin
        s2_valid <= 1'b1;
        ctr      <= ex_side.ctr_next;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_item;
    end
    if (s2_take) begin
      s2_res   <= ex_res;
      s2_is_ld <= ex_side.is_ld;
    end
  end

  // result, load data comes straight from the memory read register
  always_comb begin
    out_item = s2_res;
    if (s2_is_ld) begin
      out_item.dest_value = dm_rdata;
    end
  end

  assign out_valid = s2_valid;

  `SRIE_ASSERT_IMP(a_result_from_exec, clk, rst, $rose(out_valid), $past(s1_valid) && !$past(s1_item.kind), "result without an executed instruction")
  `SRIE_ASSERT_NXT(a_ctr_up, clk, rst, s2_take && ex_side.is_cond && ex_res.branch_taken && ctr != 2'd3, ctr == $past(ctr) + 2'd1, "branch counter did not count up")
  `SRIE_ASSERT_IMP(a_link, clk, rst, out_valid && out_item.branch_taken, out_item.reg_written && out_item.dest_reg == REG_LINK, "taken branch without link")
  `SRIE_ASSERT_IMP(a_mispredict_alone, clk, rst, out_valid && out_item.mispredicted, !out_item.stored && !out_item.halted, "mispredict on a non-branch")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import srie_pkg::*;

  localparam int unsigned N_RANDOM = 850;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned IDLE_PCT = 37;

  // directed stimulus row: typed rows carry their expected result
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // shared pacing controls, written with nonblocking assignments
  logic      steady = 1'b0;
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;

  // core state tracked by the predictor
  logic [31:0] gpr [8] = '{default: '0};
  logic [31:0] dmem [bit [15:0]];
  bit   [15:0] mem_addrs [$];
  logic [1:0]  bctr = '0;
  logic [15:0] flow_pc = '0;

  out_item_t results_due [$];
  dir_row_t  dir_rows [$];

  logic [4:0] alu_ops [8] = '{OP_ADD, OP_SUB, OP_LSF, OP_RSF, OP_AND, OP_OR, OP_XOR, OP_LHI};
  logic [4:0] jump_ops [4] = '{OP_JLT, OP_JLE, OP_JEQ, OP_JNE};

  int fail_count = 0;
  int n_in = 0;
  int n_preload = 0;
  int n_checked = 0;
  int n_taken = 0;
  int n_mispred = 0;
  int n_store = 0;
  int n_halt = 0;

  simple_risc_instruction_execute i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // operand read: zero, immediate, or register
  function automatic logic [31:0] src_value(input logic [2:0] sel, input logic [31:0] imm);
    if (sel == SEL_ZERO) return '0;
    if (sel == SEL_IMM) return imm;
    return gpr[sel];
  endfunction

  function automatic bit is_defined_op(input logic [4:0] opc);
    case (opc)
      OP_ADD, OP_SUB, OP_LSF, OP_RSF, OP_AND, OP_OR, OP_XOR, OP_LHI, OP_LD, OP_ST,
      OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN, OP_HLT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [4:0] spare_opcode();
    logic [4:0] opc;
    do opc = 5'($urandom()); while (is_defined_op(opc));
    return opc;
  endfunction

  // executes one transaction on the tracked state; returns 1 when a result is due
  function automatic bit execute_insn(input in_item_t it, output out_item_t r);
    logic [4:0]  opc;
    logic [2:0]  dst;
    logic [31:0] imm, a, b, v, old_dst;
    bit          t;
    r = '0;
    v = '0;
    if (it.kind) begin
      if (!dmem.exists(it.preload_address)) mem_addrs.push_back(it.preload_address);
      dmem[it.preload_address] = it.preload_data;
      n_preload++;
      return 1'b0;
    end
    opc = it.instruction[OPC_HI:OPC_LO];
    dst = it.instruction[DST_HI:DST_LO];
    imm = {{16{it.instruction[IMM_HI]}}, it.instruction[IMM_HI:IMM_LO]};
    a = src_value(it.instruction[SRC0_HI:SRC0_LO], imm);
    b = src_value(it.instruction[SRC1_HI:SRC1_LO], imm);
    r.next_pc = it.program_counter + 16'd1;
    case (opc)
      OP_ADD: begin r.reg_written = 1'b1; v = a + b; end
      OP_SUB: begin r.reg_written = 1'b1; v = a - b; end
      OP_LSF: begin r.reg_written = 1'b1; v = (b >= 32) ? '0 : a << b[4:0]; end
      OP_RSF: begin
        r.reg_written = 1'b1;
        v = (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
      end
      OP_AND: begin r.reg_written = 1'b1; v = a & b; end
      OP_OR:  begin r.reg_written = 1'b1; v = a | b; end
      OP_XOR: begin r.reg_written = 1'b1; v = a ^ b; end
      OP_LHI: begin
        r.reg_written = 1'b1;
        old_dst = src_value(dst, imm);
        v = {imm[15:0], old_dst[15:0]};
      end
      OP_LD: begin r.reg_written = 1'b1; v = dmem[b[15:0]]; end
      OP_ST: begin
        r.stored = 1'b1;
        r.store_address = b[15:0];
        r.store_value = a;
        if (!dmem.exists(b[15:0])) mem_addrs.push_back(b[15:0]);
        dmem[b[15:0]] = a;
      end
      OP_JLT, OP_JLE, OP_JEQ, OP_JNE: begin
        case (opc)
          OP_JLT:  t = $signed(a) < $signed(b);
          OP_JLE:  t = $signed(a) <= $signed(b);
          OP_JEQ:  t = (a == b);
          default: t = (a != b);
        endcase
        r.mispredicted = (bctr[1] != t);
        if (t) begin
          if (bctr != 2'd3) bctr++;
          r.branch_taken = 1'b1;
          r.next_pc = imm[15:0];
          r.reg_written = 1'b1;
          dst = REG_LINK;
          v = 32'({1'b0, it.program_counter} + 17'd1);
        end else if (bctr != 2'd0) begin
          bctr--;
        end
      end
      OP_JIN: begin
        r.branch_taken = 1'b1;
        r.next_pc = a[15:0];
        r.reg_written = 1'b1;
        dst = REG_LINK;
        v = 32'({1'b0, it.program_counter} + 17'd1);
      end
      OP_HLT: begin r.halted = 1'b1; r.next_pc = it.program_counter; end
      default: ;
    endcase
    if (r.reg_written) begin
      gpr[dst] = v;
      r.dest_reg = dst;
      r.dest_value = v;
    end
    flow_pc = r.next_pc;
    n_taken += int'(r.branch_taken);
    n_mispred += int'(r.mispredicted);
    n_store += int'(r.stored);
    n_halt += int'(r.halted);
    return 1'b1;
  endfunction

  function automatic in_item_t insn_item(input logic [4:0] opc, input logic [2:0] dst,
                                         input logic [2:0] s0, input logic [2:0] s1,
                                         input logic [15:0] imm, input logic [15:0] pc);
    in_item_t it;
    it = '0;
    it.instruction[OPC_HI:OPC_LO] = opc;
    it.instruction[DST_HI:DST_LO] = dst;
    it.instruction[SRC0_HI:SRC0_LO] = s0;
    it.instruction[SRC1_HI:SRC1_LO] = s1;
    it.instruction[IMM_HI:IMM_LO] = imm;
    it.program_counter = pc;
    return it;
  endfunction

  function automatic in_item_t preload_item(input logic [15:0] addr, input logic [31:0] data);
    in_item_t it;
    it = '0;
    it.kind = 1'b1;
    it.preload_address = addr;
    it.preload_data = data;
    return it;
  endfunction

  function automatic out_item_t res(input logic [15:0] npc, input logic hlt, input logic wr,
                                    input logic [2:0] rd, input logic [31:0] val,
                                    input logic tk, input logic mis, input logic st,
                                    input logic [15:0] sa, input logic [31:0] sv);
    out_item_t r;
    r.next_pc = npc;
    r.halted = hlt;
    r.reg_written = wr;
    r.dest_reg = rd;
    r.dest_value = val;
    r.branch_taken = tk;
    r.mispredicted = mis;
    r.stored = st;
    r.store_address = sa;
    r.store_value = sv;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t row;
    row.stim = it;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic string fmt_res(input out_item_t r);
    return $sformatf("npc=%h hlt=%b wr=%b rd=%0d val=%h tk=%b mis=%b st=%b sa=%h sv=%h",
                     r.next_pc, r.halted, r.reg_written, r.dest_reg, r.dest_value,
                     r.branch_taken, r.mispredicted, r.stored, r.store_address,
                     r.store_value);
  endfunction

  // mostly program-like instructions, some raw words and preloads
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [4:0]  opc;
    logic [2:0]  dst, s0, s1;
    logic [15:0] imm;
    logic [31:0] addr_op;
    int unsigned roll;
    it.kind = 1'b0;
    it.instruction = $urandom();
    it.program_counter = ($urandom_range(99) < 70) ? flow_pc : 16'($urandom());
    it.preload_address = 16'($urandom());
    it.preload_data = $urandom();
    roll = $urandom_range(99);
    if (roll < 8) begin
      it.kind = 1'b1;
      if ($urandom_range(3) != 0) it.preload_address = 16'($urandom_range(31));
      return it;
    end
    if (roll >= 13) begin
      roll = $urandom_range(99);
      if (roll < 45) opc = alu_ops[$urandom_range(7)];
      else if (roll < 60) opc = OP_LD;
      else if (roll < 72) opc = OP_ST;
      else if (roll < 92) opc = jump_ops[$urandom_range(3)];
      else if (roll < 95) opc = OP_JIN;
      else if (roll < 97) opc = OP_HLT;
      else opc = spare_opcode();
      dst = 3'($urandom());
      s0 = 3'($urandom());
      s1 = 3'($urandom());
      case ($urandom_range(5))
        0: imm = 16'hFFFF;
        1: imm = 16'h8000;
        2: imm = 16'h7FFF;
        3: imm = 16'h0000;
        4: imm = 16'($urandom_range(40));
        default: imm = 16'($urandom());
      endcase
      // shift amounts near the word size, addresses in a small window
      if ((opc == OP_LSF || opc == OP_RSF) && s1 == SEL_IMM) imm = 16'($urandom_range(40));
      if ((opc == OP_LD || opc == OP_ST) && $urandom_range(3) != 0) begin
        s1 = SEL_IMM;
        imm = 16'($urandom_range(31));
      end
      if (opc inside {OP_JLT, OP_JLE, OP_JEQ, OP_JNE} && $urandom_range(2) == 0) s1 = s0;
      it.instruction[OPC_HI:OPC_LO] = opc;
      it.instruction[DST_HI:DST_LO] = dst;
      it.instruction[SRC0_HI:SRC0_LO] = s0;
      it.instruction[SRC1_HI:SRC1_LO] = s1;
      it.instruction[IMM_HI:IMM_LO] = imm;
    end
    // loads only touch words that have been written
    if (it.instruction[OPC_HI:OPC_LO] == OP_LD) begin
      addr_op = src_value(it.instruction[SRC1_HI:SRC1_LO],
                          {{16{it.instruction[IMM_HI]}}, it.instruction[IMM_HI:IMM_LO]});
      if (!dmem.exists(addr_op[15:0])) begin
        it.instruction[SRC1_HI:SRC1_LO] = SEL_IMM;
        it.instruction[IMM_HI:IMM_LO] = mem_addrs[$urandom_range(mem_addrs.size() - 1)];
      end
    end
    return it;
  endfunction

  // offer one transaction with random idle cycles, then record its expected result
  task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_in++;
    if (execute_insn(it, pred)) results_due.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // stimulus
  initial begin : stimulus
    in_item_t spare;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    spare = insn_item(spare_opcode(), 3'd3, 3'd2, 3'd4, 16'h5A5A, 16'h2000);
    spare.instruction[31:30] = 2'b11;

    add_row(insn_item(OP_ADD, 3'd2, SEL_ZERO, SEL_IMM, 16'hFFFF, 16'h0000), 1'b1,
            res(16'h0001, 1'b0, 1'b1, 3'd2, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_ADD, 3'd3, 3'd2, SEL_ZERO, 16'h0000, 16'hFFFF), 1'b1,
            res(16'h0000, 1'b0, 1'b1, 3'd3, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_LHI, 3'd4, SEL_ZERO, SEL_ZERO, 16'h8000, 16'h0005), 1'b1,
            res(16'h0006, 1'b0, 1'b1, 3'd4, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_SUB, 3'd5, SEL_ZERO, 3'd4, 16'h0000, 16'h0006), 1'b0, '0);
    add_row(insn_item(OP_LSF, 3'd6, 3'd2, SEL_IMM, 16'd32, 16'h0007), 1'b1,
            res(16'h0008, 1'b0, 1'b1, 3'd6, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_RSF, 3'd6, 3'd4, SEL_IMM, 16'd40, 16'h0008), 1'b1,
            res(16'h0009, 1'b0, 1'b1, 3'd6, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_RSF, 3'd5, 3'd4, SEL_IMM, 16'd4, 16'h0009), 1'b0, '0);
    add_row(insn_item(OP_LSF, 3'd6, 3'd2, SEL_IMM, 16'd31, 16'h000A), 1'b0, '0);
    add_row(insn_item(OP_AND, 3'd3, 3'd4, 3'd2, 16'h0000, 16'h000B), 1'b0, '0);
    add_row(insn_item(OP_OR, 3'd3, 3'd5, SEL_IMM, 16'h1234, 16'h000C), 1'b0, '0);
    add_row(insn_item(OP_XOR, 3'd3, 3'd2, 3'd4, 16'h0000, 16'h000D), 1'b0, '0);
    add_row(preload_item(16'hFFFF, 32'hA5A5_A5A5), 1'b0, '0);
    add_row(preload_item(16'h0000, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(insn_item(OP_LD, 3'd3, SEL_ZERO, SEL_IMM, 16'hFFFF, 16'h000E), 1'b1,
            res(16'h000F, 1'b0, 1'b1, 3'd3, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_ST, 3'd0, 3'd2, SEL_IMM, 16'h0010, 16'h000F), 1'b1,
            res(16'h0010, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, 1'b0, 1'b1, 16'h0010,
                32'hFFFF_FFFF));
    add_row(insn_item(OP_LD, 3'd5, SEL_ZERO, SEL_IMM, 16'h0010, 16'h0010), 1'b0, '0);
    add_row(insn_item(OP_LHI, 3'd1, SEL_ZERO, SEL_ZERO, 16'h1234, 16'h0011), 1'b1,
            res(16'h0012, 1'b0, 1'b1, 3'd1, 32'h1234_1234, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_LHI, 3'd0, SEL_ZERO, SEL_ZERO, 16'hABCD, 16'h0012), 1'b1,
            res(16'h0013, 1'b0, 1'b1, 3'd0, 32'hABCD_0000, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(insn_item(OP_JEQ, 3'd0, SEL_ZERO, SEL_ZERO, 16'h0100, 16'hFFFF), 1'b1,
            res(16'h0100, 1'b0, 1'b1, REG_LINK, 32'h0001_0000, 1'b1, 1'b1, 1'b0, 16'h0,
                32'h0));
    add_row(insn_item(OP_JNE, 3'd0, SEL_ZERO, SEL_ZERO, 16'h0200, 16'h0100), 1'b0, '0);
    add_row(insn_item(OP_JLT, 3'd0, 3'd4, SEL_ZERO, 16'h0300, 16'h0101), 1'b0, '0);
    add_row(insn_item(OP_JLE, 3'd0, SEL_ZERO, SEL_ZERO, 16'h0400, 16'h0300), 1'b0, '0);
    add_row(insn_item(OP_JLT, 3'd0, SEL_ZERO, 3'd4, 16'h0500, 16'h0400), 1'b0, '0);
    add_row(insn_item(OP_JIN, 3'd0, 3'd2, SEL_ZERO, 16'h0000, 16'h0401), 1'b0, '0);
    add_row(insn_item(OP_HLT, 3'd0, SEL_ZERO, SEL_ZERO, 16'h0000, 16'h1234), 1'b1,
            res(16'h1234, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));
    add_row(spare, 1'b1,
            res(16'h2001, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0));

    foreach (dir_rows[i]) offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // random program traffic with pacing events along the way
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 250) hold_req <= 1'b1;
      if (n == 400) steady <= 1'b1;
      if (n == 550) steady <= 1'b0;
      if (n == 650) wait_drained();
      offer(random_item(), 1'b0, '0);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    fail_count += results_due.size();
    $display("sent %0d transactions (%0d preloads), checked %0d results", n_in, n_preload,
             n_checked);
    $display("branches taken %0d, mispredicts %0d, stores %0d, halts %0d", n_taken,
             n_mispred, n_store, n_halt);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver pacing, with one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    string     diff;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %s", fmt_res(out_item));
      end else begin
        want = results_due.pop_front();
        diff = "";
        if (out_item.next_pc !== want.next_pc) diff = {diff, " next_pc"};
        if (out_item.halted !== want.halted) diff = {diff, " halted"};
        if (out_item.reg_written !== want.reg_written) diff = {diff, " reg_written"};
        if (out_item.dest_reg !== want.dest_reg) diff = {diff, " dest_reg"};
        if (out_item.dest_value !== want.dest_value) diff = {diff, " dest_value"};
        if (out_item.branch_taken !== want.branch_taken) diff = {diff, " branch_taken"};
        if (out_item.mispredicted !== want.mispredicted) diff = {diff, " mispredicted"};
        if (out_item.stored !== want.stored) diff = {diff, " stored"};
        if (out_item.store_address !== want.store_address) diff = {diff, " store_address"};
        if (out_item.store_value !== want.store_value) diff = {diff, " store_value"};
        if (diff != "") begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch on result %0d in%s", n_checked, diff);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(out_item));
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
